[hdl/unit_pool_allocator_core_macros.svh]
// Assertion macros used by the datapath RTL of the unit pool allocator.
// Both macros sample on i_clk and are switched off while i_rst_n is low.
`ifndef UNIT_POOL_ALLOCATOR_CORE_MACROS_SVH
`define UNIT_POOL_ALLOCATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge out of reset.
`define UPA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("upa: check failed");

// Consequence that must hold in the cycle after the antecedent.
`define UPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("upa: sequence check failed");

`else

`define UPA_ASSERT(lbl, prop)
`define UPA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[hdl/upa_pkg.sv]
`default_nettype none

package upa_pkg;

    typedef enum logic [2:0] {
        KIND_GRANT       = 3'd0,
        KIND_QUEUED      = 3'd1,
        KIND_RELEASED    = 3'd2,
        KIND_TOO_LARGE   = 3'd3,
        KIND_BAD_RELEASE = 3'd4,
        KIND_QUEUE_FULL  = 3'd5,
        KIND_EMPTY_GRANT = 3'd6
    } t_kind;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [3:0] count;
        logic [3:0] unit_index;
        logic       release_last;
    } t_req;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] granted_unit;
        logic [7:0] ticket;
        logic       run_last;
    } t_res;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_TOO_LARGE,
        OP_EMPTY,
        OP_GRANT_START,
        OP_QUEUE_FULL,
        OP_ENQUEUE,
        OP_BAD_RELEASE,
        OP_RELEASE,
        OP_RELEASE_WAKE,
        OP_GRANT_UNIT,
        OP_SKIP
    } t_op;

    typedef struct packed {
        logic load;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic is_release;
        logic too_large;
        logic zero_count;
        logic fits;
        logic queue_full;
        logic bad_release;
        logic wake;
        logic unit_free;
        logic last_unit;
        logic out_room;
    } t_stat;

endpackage

`default_nettype wire

[hdl/upa_channels.sv]
`default_nettype none

interface upa_req_if;
    import upa_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface upa_res_if;
    import upa_pkg::*;
    logic valid;
    logic ready;
    t_res payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hdl/upa_ctrl.sv]
`default_nettype none

module upa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  upa_pkg::t_stat i_stat,
    output upa_pkg::t_cmd  o_cmd
);
    import upa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_DECIDE = 3'b010,
        S_GRANT  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.op   = OP_NONE;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.out_room) begin
                    n_state = S_IDLE;
                    if (!i_stat.is_release) begin
                        if (i_stat.too_large) begin
                            o_cmd.op = OP_TOO_LARGE;
                        end else if (i_stat.zero_count) begin
                            o_cmd.op = OP_EMPTY;
                        end else if (i_stat.fits) begin
                            o_cmd.op = OP_GRANT_START;
                            n_state  = S_GRANT;
                        end else if (i_stat.queue_full) begin
                            o_cmd.op = OP_QUEUE_FULL;
                        end else begin
                            o_cmd.op = OP_ENQUEUE;
                        end
                    end else if (i_stat.bad_release) begin
                        o_cmd.op = OP_BAD_RELEASE;
                    end else if (i_stat.wake) begin
                        o_cmd.op = OP_RELEASE_WAKE;
                        n_state  = S_GRANT;
                    end else begin
                        o_cmd.op = OP_RELEASE;
                    end
                end
            end
            S_GRANT: begin
                // walk the map one unit a cycle; hold on a taken output slot
                if (!i_stat.unit_free) begin
                    o_cmd.op = OP_SKIP;
                end else if (i_stat.out_room) begin
                    o_cmd.op = OP_GRANT_UNIT;
                    if (i_stat.last_unit) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[hdl/upa_dp.sv]
`default_nettype none
`include "unit_pool_allocator_core_macros.svh"

module upa_dp #(
    parameter int NUNITS      = 10,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  upa_pkg::t_cmd  i_cmd,
    input  upa_pkg::t_req  i_req,
    output upa_pkg::t_stat o_stat,
    output logic           o_res_valid,
    input  logic           i_res_ready,
    output upa_pkg::t_res  o_res
);
    import upa_pkg::*;

    localparam int SW = (NUNITS > 1) ? $clog2(NUNITS) : 1;
    localparam int FW = $clog2(NUNITS + 1);
    localparam int CW = ((FW > 4) ? FW : 4) + 1;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [3:0] count;
        logic [7:0] ticket;
    } t_wait;

    t_req              r_item;
    logic [NUNITS-1:0] r_busy,    n_busy;
    logic [FW-1:0]     r_free,    n_free;
    logic [7:0]        r_holder,  n_holder;
    logic [QW-1:0]     r_head,    n_head;
    logic [LW-1:0]     r_fill,    n_fill;
    logic [7:0]        r_ticket,  n_ticket;
    logic [3:0]        r_rem,     n_rem;
    logic [7:0]        r_gticket, n_gticket;
    logic [SW-1:0]     r_scan,    n_scan;
    logic              r_res_valid, n_res_valid;
    t_res              r_res,     n_res;
    t_wait             r_queue [QUEUE_DEPTH];
    t_wait             r_qrd;

    logic              q_wr;
    logic              emit;
    logic [QW:0]       tail_sum;
    logic [QW-1:0]     tail;
    logic [QW-1:0]     head_adv;
    logic [NUNITS-1:0] idx_dec;
    logic [CW-1:0]     cnt_x;
    logic [CW-1:0]     free_x;
    logic [CW-1:0]     free_inc;
    logic [CW-1:0]     qcnt_x;
    logic [7:0]        holder_dec;
    logic [7:0]        holder_inc;

    // one-hot decode of the unit being released (all zero when out of range)
    always_comb begin
        for (int i = 0; i < NUNITS; i++) begin
            idx_dec[i] = (CW'(r_item.unit_index) == CW'(i));
        end
    end

    assign tail_sum   = {1'b0, r_head} + (QW+1)'(r_fill);
    assign tail       = (tail_sum >= (QW+1)'(QUEUE_DEPTH))
                        ? QW'(tail_sum - (QW+1)'(QUEUE_DEPTH)) : QW'(tail_sum);
    assign head_adv   = (r_head == QW'(QUEUE_DEPTH - 1)) ? '0 : r_head + QW'(1);
    assign cnt_x      = CW'(r_item.count);
    assign free_x     = CW'(r_free);
    assign free_inc   = free_x + CW'(1);
    assign qcnt_x     = CW'(r_qrd.count);
    assign holder_dec = (r_holder != 8'd0) ? r_holder - 8'd1 : r_holder;
    assign holder_inc = (r_holder != 8'hFF) ? r_holder + 8'd1 : r_holder;

    always_comb begin
        o_stat.is_release  = (r_item.req_type == REQ_RELEASE);
        o_stat.too_large   = (cnt_x > CW'(NUNITS));
        o_stat.zero_count  = (r_item.count == 4'd0);
        o_stat.fits        = (cnt_x <= free_x);
        o_stat.queue_full  = (r_fill >= LW'(QUEUE_DEPTH));
        o_stat.bad_release = ~|(r_busy & idx_dec);
        o_stat.wake        = r_item.release_last && (holder_dec == 8'd0)
                             && (r_fill != '0) && (r_qrd.count != 4'd0)
                             && (qcnt_x <= free_inc);
        o_stat.unit_free   = !r_busy[r_scan];
        o_stat.last_unit   = (r_rem == 4'd1);
        o_stat.out_room    = !r_res_valid || i_res_ready;
    end

    always_comb begin
        n_busy    = r_busy;
        n_free    = r_free;
        n_holder  = r_holder;
        n_head    = r_head;
        n_fill    = r_fill;
        n_ticket  = r_ticket;
        n_rem     = r_rem;
        n_gticket = r_gticket;
        n_scan    = r_scan;
        n_res     = r_res;
        q_wr      = 1'b0;
        emit      = 1'b0;
        case (i_cmd.op)
            OP_TOO_LARGE: begin
                emit  = 1'b1;
                n_res = '{KIND_TOO_LARGE, 4'd0, 8'd0, 1'b1};
            end
            OP_EMPTY: begin
                emit     = 1'b1;
                n_res    = '{KIND_EMPTY_GRANT, 4'd0, r_ticket, 1'b1};
                n_ticket = r_ticket + 8'd1;
                n_holder = holder_inc;
            end
            OP_GRANT_START: begin
                n_ticket  = r_ticket + 8'd1;
                n_holder  = holder_inc;
                n_free    = r_free - FW'(r_item.count);
                n_rem     = r_item.count;
                n_gticket = r_ticket;
                n_scan    = '0;
            end
            OP_QUEUE_FULL: begin
                emit  = 1'b1;
                n_res = '{KIND_QUEUE_FULL, 4'd0, 8'd0, 1'b1};
            end
            OP_ENQUEUE: begin
                emit     = 1'b1;
                q_wr     = 1'b1;
                n_res    = '{KIND_QUEUED, 4'd0, r_ticket, 1'b1};
                n_fill   = r_fill + LW'(1);
                n_ticket = r_ticket + 8'd1;
            end
            OP_BAD_RELEASE: begin
                emit  = 1'b1;
                n_res = '{KIND_BAD_RELEASE, 4'd0, 8'd0, 1'b1};
            end
            OP_RELEASE: begin
                emit   = 1'b1;
                n_res  = '{KIND_RELEASED, r_item.unit_index, 8'd0, 1'b1};
                n_busy = r_busy & ~idx_dec;
                n_free = r_free + FW'(1);
                if (r_item.release_last) begin
                    n_holder = holder_dec;
                end
            end
            OP_RELEASE_WAKE: begin
                // last holder gone: hand the pool to the oldest waiter
                emit      = 1'b1;
                n_res     = '{KIND_RELEASED, r_item.unit_index, 8'd0, 1'b0};
                n_busy    = r_busy & ~idx_dec;
                n_free    = FW'(free_inc - qcnt_x);
                n_holder  = 8'd1;
                n_head    = head_adv;
                n_fill    = r_fill - LW'(1);
                n_rem     = r_qrd.count;
                n_gticket = r_qrd.ticket;
                n_scan    = '0;
            end
            OP_GRANT_UNIT: begin
                emit           = 1'b1;
                n_res          = '{KIND_GRANT, 4'(r_scan), r_gticket, (r_rem == 4'd1)};
                n_busy[r_scan] = 1'b1;
                n_rem          = r_rem - 4'd1;
                n_scan         = r_scan + SW'(1);
            end
            OP_SKIP: begin
                n_scan = r_scan + SW'(1);
            end
            default: begin
            end
        endcase
        if (emit) begin
            n_res_valid = 1'b1;
        end else if (i_res_ready) begin
            n_res_valid = 1'b0;
        end else begin
            n_res_valid = r_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= '0;
            r_free      <= FW'(NUNITS);
            r_holder    <= 8'd0;
            r_head      <= '0;
            r_fill      <= '0;
            r_ticket    <= 8'd0;
            r_rem       <= 4'd0;
            r_scan      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_free      <= n_free;
            r_holder    <= n_holder;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_ticket    <= n_ticket;
            r_rem       <= n_rem;
            r_scan      <= n_scan;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_req;
        end
        r_gticket <= n_gticket;
        r_res     <= n_res;
    end

    // waiter queue: write at the tail, registered read at the head
    always_ff @(posedge i_clk) begin
        if (q_wr) begin
            r_queue[tail] <= '{r_item.count, r_ticket};
        end
        r_qrd <= r_queue[r_head];
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    `UPA_ASSERT(a_free_matches_map, (r_rem != 4'd0) || ((int'(r_free) + $countones(r_busy)) == NUNITS))
    `UPA_ASSERT(a_fill_bound, r_fill <= LW'(QUEUE_DEPTH))
    `UPA_ASSERT(a_grant_unit_free, (i_cmd.op != OP_GRANT_UNIT) || !r_busy[r_scan])
    `UPA_ASSERT_NEXT(a_wake_dequeues, i_cmd.op == OP_RELEASE_WAKE, r_fill == $past(r_fill) - LW'(1))

endmodule

`default_nettype wire

[hdl/unit_pool_allocator_core.sv]
// Channel  Dir  Interface        Contents
// i_req    in   upa_req_if.sink  allocate (count) or release one unit
// o_res    out  upa_res_if.source kind, unit, ticket, run_last per result
//
// An item is taken in the idle state and decided in S_DECIDE once the output
// register has room. A grant (or a release that wakes a waiter) then walks the
// busy map one unit a cycle from index 0 until all requested units are handed
// out. Output stalls hold the controller wherever a result is due.
// Reset is synchronous, active low; the waiter queue memory needs no clearing.
`default_nettype none

module unit_pool_allocator_core #(
    parameter int NUNITS      = 10,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    upa_req_if.sink   i_req,
    upa_res_if.source o_res
);
    import upa_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;
    logic  res_valid;
    t_res  res;

    // Controller: one transaction in at a time, sequencing the datapath
    upa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Datapath: busy map, counters, waiter queue and the output register
    upa_dp #(
        .NUNITS      (NUNITS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (i_req.payload),
        .o_stat      (stat),
        .o_res_valid (res_valid),
        .i_res_ready (o_res.ready),
        .o_res       (res)
    );

    assign i_req.ready   = in_ready;
    assign o_res.valid   = res_valid;
    assign o_res.payload = res;

endmodule

`default_nettype wire

[dv/tb_unit_pool_allocator_core.sv]
`timescale 1ns / 100ps

import upa_pkg::*;

// Holds the expected pool state and the expected results of every accepted request.
class pool_ledger #(int UNITS = 10, int DEPTH = 8);
    logic [UNITS-1:0] unit_busy;
    logic [7:0]       unit_ticket [UNITS];
    int unsigned      free_units;
    int unsigned      holder_count;
    logic [3:0]       wait_count [DEPTH];
    logic [7:0]       wait_ticket [DEPTH];
    int unsigned      queue_head;
    int unsigned      queue_fill;
    logic [7:0]       next_ticket;
    int               wakeups;
    t_res             expected_results [$];

    function new();
        unit_busy    = '0;
        free_units   = UNITS;
        holder_count = 0;
        queue_head   = 0;
        queue_fill   = 0;
        next_ticket  = '0;
        wakeups      = 0;
        foreach (unit_ticket[i]) unit_ticket[i] = '0;
        foreach (wait_count[i]) begin
            wait_count[i]  = '0;
            wait_ticket[i] = '0;
        end
    endfunction

    function void push_result(t_kind kind, logic [3:0] unit, logic [7:0] ticket, logic last);
        t_res r;
        r.kind         = kind;
        r.granted_unit = unit;
        r.ticket       = ticket;
        r.run_last     = last;
        expected_results.push_back(r);
    endfunction

    function logic [7:0] take_ticket();
        logic [7:0] t;
        t           = next_ticket;
        next_ticket = next_ticket + 8'd1;
        return t;
    endfunction

    // Hand out n free units, lowest index first, flagging the last one.
    function void grant_units(int unsigned n, logic [7:0] ticket);
        int unsigned got;
        got = 0;
        if (holder_count < 255) holder_count++;
        free_units -= n;
        for (int i = 0; i < UNITS && got < n; i++) begin
            if (!unit_busy[i]) begin
                unit_busy[i]   = 1'b1;
                unit_ticket[i] = ticket;
                got++;
                push_result(KIND_GRANT, 4'(i), ticket, got == n);
            end
        end
    endfunction

    function void note_request(t_req item);
        int unsigned slot;
        logic [3:0]  n;
        logic [7:0]  t;
        if (item.req_type == REQ_ALLOC) begin
            if (item.count > UNITS) begin
                push_result(KIND_TOO_LARGE, '0, '0, 1'b1);
            end else if (item.count == 0) begin
                t = take_ticket();
                if (holder_count < 255) holder_count++;
                push_result(KIND_EMPTY_GRANT, '0, t, 1'b1);
            end else if (item.count <= free_units) begin
                grant_units(item.count, take_ticket());
            end else if (queue_fill >= DEPTH) begin
                push_result(KIND_QUEUE_FULL, '0, '0, 1'b1);
            end else begin
                slot              = (queue_head + queue_fill) % DEPTH;
                wait_count[slot]  = item.count;
                wait_ticket[slot] = take_ticket();
                queue_fill++;
                push_result(KIND_QUEUED, '0, wait_ticket[slot], 1'b1);
            end
        end else if (item.unit_index >= UNITS || !unit_busy[item.unit_index]) begin
            push_result(KIND_BAD_RELEASE, '0, '0, 1'b1);
        end else begin
            unit_busy[item.unit_index] = 1'b0;
            free_units++;
            if (item.release_last) begin
                if (holder_count > 0) holder_count--;
                n = wait_count[queue_head];
                if (holder_count == 0 && queue_fill > 0 && n >= 1 && n <= free_units) begin
                    t          = wait_ticket[queue_head];
                    queue_head = (queue_head + 1) % DEPTH;
                    queue_fill--;
                    wakeups++;
                    push_result(KIND_RELEASED, item.unit_index, '0, 1'b0);
                    grant_units(n, t);
                    return;
                end
            end
            push_result(KIND_RELEASED, item.unit_index, '0, 1'b1);
        end
    endfunction

    // Return an empty string on a match, else a one-line description.
    function string check_result(t_res got);
        t_res want;
        if (expected_results.size() == 0)
            return $sformatf("unexpected result kind=%0d unit=%0d ticket=%0d last=%0b",
                             got.kind, got.granted_unit, got.ticket, got.run_last);
        want = expected_results.pop_front();
        if (got.kind !== want.kind || got.granted_unit !== want.granted_unit ||
            got.ticket !== want.ticket || got.run_last !== want.run_last)
            return $sformatf("got kind=%0d unit=%0d ticket=%0d last=%0b, want %0d/%0d/%0d/%0b",
                             got.kind, got.granted_unit, got.ticket, got.run_last,
                             want.kind, want.granted_unit, want.ticket, want.run_last);
        return "";
    endfunction
endclass

module tb_unit_pool_allocator_core;

    localparam int NUNITS      = 10;
    localparam int QUEUE_DEPTH = 8;
    // Cycles to let pass once nothing is expected: a full grant scan plus slack.
    localparam int TAIL_CYCLES = NUNITS + 4;
    // Cycles without any transaction before the run is declared hung.
    localparam int STALL_LIMIT = 2000;
    localparam int PRINT_LIMIT = 100;

    logic i_clk = 1'b0;
    logic i_rst_n;

    upa_req_if req_if ();
    upa_res_if res_if ();

    unit_pool_allocator_core #(
        .NUNITS      (NUNITS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    pool_ledger #(NUNITS, QUEUE_DEPTH) ledger;

    int mismatches    = 0;
    int requests_seen = 0;
    int results_seen  = 0;
    int quiet_cycles  = 0;
    int kind_seen [8];
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Drop ready at random on the falling edge so stalls land on every phase of a grant.
    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Observe both channels on the rising edge. Check results before noting the
    // request of the same edge, so a result can never match an expectation that
    // is only created in the same cycle.
    always @(posedge i_clk) begin : observe
        string verdict;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                verdict = ledger.check_result(res_if.payload);
                if (verdict != "") report_mismatch(verdict);
                results_seen++;
                kind_seen[res_if.payload.kind]++;
            end
            if (req_if.valid && req_if.ready) begin
                ledger.note_request(req_if.payload);
                requests_seen++;
            end
            if ((res_if.valid && res_if.ready) || (req_if.valid && req_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic t_req alloc_req(input int n);
        t_req item;
        item              = '0;
        item.req_type     = REQ_ALLOC;
        item.count        = 4'(n);
        return item;
    endfunction

    function automatic t_req release_req(input int unit, input bit last);
        t_req item;
        item              = '0;
        item.req_type     = REQ_RELEASE;
        item.unit_index   = 4'(unit);
        item.release_last = last;
        return item;
    endfunction

    // Enter and leave on a falling edge. Hold valid high across back-to-back
    // transactions; lower it only for an idle cycle.
    task automatic send_item(input t_req item);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= item;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every expected result is in, then let the
    // block settle before the next phase.
    task automatic hold_until_drained();
        req_if.valid <= 1'b0;
        while (ledger.expected_results.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    // Mostly well-formed traffic: allocations of a few units and releases of
    // units actually held, with release_last on a holder's final unit. Flag
    // extra holders (empty grants) on any release so waiters still get woken.
    // One item in ten carries raw random fields.
    function automatic t_req random_request();
        t_req     item;
        int       live [$];
        bit [255:0] owners;
        int       others;
        int       u;
        int       roll;
        item.req_type     = REQ_ALLOC;
        item.count        = 4'($urandom_range(15));
        item.unit_index   = 4'($urandom_range(15));
        item.release_last = 1'($urandom_range(1));
        roll              = $urandom_range(99);
        owners            = '0;
        for (int i = 0; i < NUNITS; i++) begin
            if (ledger.unit_busy[i]) begin
                live.push_back(i);
                owners[ledger.unit_ticket[i]] = 1'b1;
            end
        end
        if (roll < 10) begin
            item.req_type = 1'($urandom_range(1));
        end else if (live.size() == 0 || (ledger.free_units > 0 && roll < 55)) begin
            if ($urandom_range(99) < 80) item.count = 4'($urandom_range(5, 1));
        end else begin
            u      = live[$urandom_range(live.size() - 1)];
            others = 0;
            foreach (live[i])
                if (live[i] != u && ledger.unit_ticket[live[i]] == ledger.unit_ticket[u])
                    others++;
            item.req_type     = REQ_RELEASE;
            item.unit_index   = 4'(u);
            item.release_last = (others == 0) || (ledger.holder_count > $countones(owners));
        end
        return item;
    endfunction

    task automatic send_random(input int n);
        repeat (n) send_item(random_request());
    endtask

    initial begin
        ledger         = new();
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        res_if.ready   = 1'b0;
        foreach (kind_seen[i]) kind_seen[i] = 0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Phase one: sender idles rarely, receiver often.
        src_idle_pct  = 10;
        sink_idle_pct = 48;

        // Directed: empty grant, oversize counts, both kinds of bad release.
        send_item(alloc_req(0));
        send_item(alloc_req(NUNITS + 1));
        send_item(alloc_req(15));
        send_item(release_req(15, 1'b0));
        send_item(release_req(3, 1'b1));
        // Take the whole pool, then fill the waiter queue and overflow it.
        send_item(alloc_req(NUNITS));
        send_item(alloc_req(3));
        repeat (6) send_item(alloc_req(1));
        send_item(alloc_req(NUNITS));
        send_item(alloc_req(2));
        // Drop both holders; the oldest waiter still does not fit and keeps waiting.
        send_item(release_req(0, 1'b1));
        send_item(release_req(1, 1'b1));
        // Holder count stays at zero; the waiter now fits and is woken.
        send_item(release_req(2, 1'b1));
        // Free one unit without ending the holder; a fitting request jumps the queue.
        send_item(release_req(9, 1'b0));
        send_item(alloc_req(1));

        hold_until_drained();
        send_random(66);
        hold_until_drained();

        // Phase two: sender idles often, receiver rarely.
        src_idle_pct  = 48;
        sink_idle_pct = 10;
        send_random(67);
        hold_until_drained();

        // Phase three: full rate on both sides.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_random(67);
        hold_until_drained();

        if (ledger.expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived",
                                      ledger.expected_results.size()));

        $display("summary: %0d requests, %0d results, %0d waiter wakeups, %0d mismatches",
                 requests_seen, results_seen, ledger.wakeups, mismatches);
        $display("summary: grant %0d queued %0d released %0d too-large %0d bad %0d full %0d empty %0d",
                 kind_seen[KIND_GRANT], kind_seen[KIND_QUEUED], kind_seen[KIND_RELEASED],
                 kind_seen[KIND_TOO_LARGE], kind_seen[KIND_BAD_RELEASE],
                 kind_seen[KIND_QUEUE_FULL], kind_seen[KIND_EMPTY_GRANT]);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
